[rtl/core/rotation_matrix_to_quaternion_defines.svh]
// assertion helpers for the matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTH
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RMQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RMQ_ASSERT(label, prop, msg)
`define RMQ_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[rtl/core/rmq_pkg.sv]
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int NUM_W = 17;

  // slot codes for the component that takes half the root
  localparam logic [1:0] SLOT_X = 2'd0;
  localparam logic [1:0] SLOT_Y = 2'd1;
  localparam logic [1:0] SLOT_Z = 2'd2;
  localparam logic [1:0] SLOT_W = 2'd3;

  typedef struct packed {
    logic signed [15:0] row0_col0;
    logic signed [15:0] row0_col1;
    logic signed [15:0] row0_col2;
    logic signed [15:0] row1_col0;
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row2_col0;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic signed [15:0] scalar_part;
    logic               clamped;
  } out_word_t;

  // classified word: numerators per slot, half-root slot, clamp flag
  typedef struct packed {
    logic [3:0][NUM_W-1:0] num;
    logic [1:0]            half_slot;
    logic                  clamp;
  } cls_t;

endpackage

[rtl/core/rotation_matrix_to_quaternion.sv]
// Rotation matrix to unit quaternion.
// Input channel in_valid_i/in_ready_o carries one 3x3 matrix word of nine
// signed elements with FRAC_BITS fraction bits; output channel
// out_valid_o/out_ready_i carries the quaternion (x, y, z, w) and a flag
// that is set when a negative root argument was clamped to zero.
// A front register classifies the word (trace sign, largest diagonal) and
// forms the root argument and numerators; a two-word queue decouples it
// from the back pipeline, which computes the floor square root one bit per
// stage and then four restoring dividers one quotient bit per stage.
// Throughput is one word per cycle while the receiver does not stall.
// The back pipeline has RW = ceil((UW + FRAC_BITS) / 2) root stages and
// DW = 17 + FRAC_BITS divider stages.
// When the receiver stalls the whole back pipeline holds, the queue fills
// and in_ready_o drops once the front register is also full.
// Reset clears all valid bits; no words are in flight after reset.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int UW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int QW = UW + $bits(cls_t);

  logic          f_valid, f_ready;
  logic [UW-1:0] f_arg, b_arg;
  cls_t          f_cls, b_cls;
  logic          b_valid, b_pop;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .UW(UW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_word_i,
    .cls_valid_o(f_valid), .cls_ready_i(f_ready),
    .cls_arg_o(f_arg), .cls_o(f_cls)
  );

  rmq_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready),
    .push_data_i({f_arg, f_cls}),
    .pop_valid_o(b_valid), .pop_i(b_pop),
    .pop_data_o({b_arg, b_cls})
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS), .UW(UW)) u_back (
    .clk_i, .rst_ni,
    .cls_valid_i(b_valid), .cls_pop_o(b_pop),
    .cls_arg_i(b_arg), .cls_i(b_cls),
    .out_valid_o, .out_ready_i, .out_word_o
  );

  // a clamped root argument gives a zero root and so a zero quaternion
  `RMQ_ASSERT(a_clamp_zero, !(out_valid_o && out_word_o.clamped) || (out_word_o.vec_x == 16'sd0 && out_word_o.vec_y == 16'sd0 && out_word_o.vec_z == 16'sd0 && out_word_o.scalar_part == 16'sd0), "clamped word with nonzero component")
  // stalled output word holds
  `RMQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o), "output word changed under stall")

endmodule

[rtl/core/rmq_front.sv]
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int UW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_word_t      in_word_i,
  output logic          cls_valid_o,
  input  logic          cls_ready_i,
  output logic [UW-1:0] cls_arg_o,
  output cls_t          cls_o
);

  localparam int SW = UW + 1;

  logic          valid_q;
  logic [UW-1:0] arg_q, arg_d;
  cls_t          cls_q, cls_d;

  logic signed [SW-1:0] m00, m11, m22, trace, one, arg_s;
  logic signed [SW-1:0] mii, mjj, mkk;
  logic [1:0] axis;

  function automatic logic [NUM_W-1:0] sub2(logic [15:0] a, logic [15:0] b);
    return {a[15], a} - {b[15], b};
  endfunction

  function automatic logic [NUM_W-1:0] add2(logic [15:0] a, logic [15:0] b);
    return {a[15], a} + {b[15], b};
  endfunction

  assign m00 = {{(SW-16){in_word_i.row0_col0[15]}}, in_word_i.row0_col0};
  assign m11 = {{(SW-16){in_word_i.row1_col1[15]}}, in_word_i.row1_col1};
  assign m22 = {{(SW-16){in_word_i.row2_col2[15]}}, in_word_i.row2_col2};
  assign trace = m00 + m11 + m22;
  assign one = SW'(1) << FRAC_BITS;

  // largest diagonal, later index only on strictly greater
  always_comb begin
    axis = 2'd0;
    if (m11 > m00) axis = 2'd1;
    if (m22 > ((axis == 2'd1) ? m11 : m00)) axis = 2'd2;
  end

  // classify and form numerators
  always_comb begin
    mii = m00;
    mjj = m11;
    mkk = m22;
    cls_d.num = '0;
    cls_d.clamp = 1'b0;
    if (trace > 0) begin
      cls_d.half_slot = SLOT_W;
      cls_d.num[0] = sub2(in_word_i.row1_col2, in_word_i.row2_col1);
      cls_d.num[1] = sub2(in_word_i.row2_col0, in_word_i.row0_col2);
      cls_d.num[2] = sub2(in_word_i.row0_col1, in_word_i.row1_col0);
      arg_s = trace + one;
    end else begin
      case (axis)
        2'd0: begin
          cls_d.half_slot = SLOT_X;
          cls_d.num[3] = sub2(in_word_i.row1_col2, in_word_i.row2_col1);
          cls_d.num[1] = add2(in_word_i.row0_col1, in_word_i.row1_col0);
          cls_d.num[2] = add2(in_word_i.row0_col2, in_word_i.row2_col0);
        end
        2'd1: begin
          mii = m11; mjj = m22; mkk = m00;
          cls_d.half_slot = SLOT_Y;
          cls_d.num[3] = sub2(in_word_i.row2_col0, in_word_i.row0_col2);
          cls_d.num[2] = add2(in_word_i.row1_col2, in_word_i.row2_col1);
          cls_d.num[0] = add2(in_word_i.row1_col0, in_word_i.row0_col1);
        end
        default: begin
          mii = m22; mjj = m00; mkk = m11;
          cls_d.half_slot = SLOT_Z;
          cls_d.num[3] = sub2(in_word_i.row0_col1, in_word_i.row1_col0);
          cls_d.num[0] = add2(in_word_i.row2_col0, in_word_i.row0_col2);
          cls_d.num[1] = add2(in_word_i.row2_col1, in_word_i.row1_col2);
        end
      endcase
      arg_s = mii - (mjj + mkk) + one;
      if (arg_s < 0) begin
        arg_s = '0;
        cls_d.clamp = 1'b1;
      end
    end
    arg_d = arg_s[UW-1:0];
  end

  assign in_ready_o = !valid_q || cls_ready_i;

  // front register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      arg_q <= arg_d;
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = valid_q;
  assign cls_arg_o   = arg_q;
  assign cls_o       = cls_q;

endmodule

[rtl/core/rmq_fifo.sv]
module rmq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [1:0][WIDTH-1:0] buf_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = buf_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[rtl/core/rmq_back.sv]
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int UW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cls_valid_i,
  output logic          cls_pop_o,
  input  logic [UW-1:0] cls_arg_i,
  input  cls_t          cls_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_word_t     out_word_o
);

  localparam int RW  = (UW + FRAC_BITS + 1) / 2;
  localparam int RW2 = 2 * RW;
  localparam int RMW = RW + 3;
  localparam int DW  = NUM_W + FRAC_BITS;

  typedef struct packed {
    logic [RW2-1:0] rad;
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    cls_t           cls;
  } sq_t;

  typedef struct packed {
    logic [3:0][DW-1:0] dq;
    logic [3:0][RW:0]   rem;
    logic [3:0]         neg;
    logic [RW-1:0]      root;
    logic [1:0]         half_slot;
    logic               clamp;
  } dv_t;

  logic           en;
  logic [RW:0]    sq_vld_q;
  sq_t            sq_q [RW+1];
  logic [DW:0]    dv_vld_q;
  dv_t            dv_q [DW+1];
  logic           out_valid_q;
  out_word_t      out_q, out_d;

  // whole back pipeline moves when the output register can take a word
  assign en        = !out_valid_q || out_ready_i;
  assign cls_pop_o = en;

  // entry of the root pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rad  <= RW2'({cls_arg_i, {FRAC_BITS{1'b0}}});
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].cls  <= cls_i;
    end
  end

  // floor square root, one result bit per stage
  for (genvar s = 0; s < RW; s++) begin : g_sqrt
    logic [RMW-1:0] rem_sh, trial;
    logic           ge;
    assign rem_sh = {sq_q[s].rem[RMW-3:0], sq_q[s].rad[RW2-1 -: 2]};
    assign trial  = {{(RMW-RW-2){1'b0}}, sq_q[s].root, 2'b01};
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[s+1].rad  <= sq_q[s].rad << 2;
        sq_q[s+1].rem  <= ge ? (rem_sh - trial) : rem_sh;
        sq_q[s+1].root <= {sq_q[s].root[RW-2:0], ge};
        sq_q[s+1].cls  <= sq_q[s].cls;
      end
    end
  end

  // entry of the divider lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        dv_q[0].dq[l]  <= {(sq_q[RW].cls.num[l][NUM_W-1] ? -sq_q[RW].cls.num[l]
                                                          : sq_q[RW].cls.num[l]),
                           {FRAC_BITS{1'b0}}};
        dv_q[0].rem[l] <= '0;
        dv_q[0].neg[l] <= sq_q[RW].cls.num[l][NUM_W-1];
      end
      dv_q[0].root      <= sq_q[RW].root;
      dv_q[0].half_slot <= sq_q[RW].cls.half_slot;
      dv_q[0].clamp     <= sq_q[RW].cls.clamp;
    end
  end

  // restoring division by twice the root, one quotient bit per stage
  for (genvar t = 0; t < DW; t++) begin : g_div
    logic [RW:0] den;
    assign den = {dv_q[t].root, 1'b0};
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [RW+1:0] rem_sh;
      logic          ge;
      assign rem_sh = {dv_q[t].rem[l], dv_q[t].dq[l][DW-1]};
      assign ge     = (rem_sh >= {1'b0, den});
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[t+1].dq[l]  <= {dv_q[t].dq[l][DW-2:0], ge};
          dv_q[t+1].rem[l] <= ge ? (RW+1)'(rem_sh - {1'b0, den})
                                 : rem_sh[RW:0];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[t+1].neg       <= dv_q[t].neg;
        dv_q[t+1].root      <= dv_q[t].root;
        dv_q[t+1].half_slot <= dv_q[t].half_slot;
        dv_q[t+1].clamp     <= dv_q[t].clamp;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q    <= '0;
      dv_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sq_vld_q    <= {sq_vld_q[RW-1:0], cls_valid_i};
      dv_vld_q    <= {dv_vld_q[DW-1:0], sq_vld_q[RW]};
      out_valid_q <= dv_vld_q[DW];
    end
  end

  // saturate, place half root, zero root gives zero
  always_comb begin
    logic [3:0][15:0] comp;
    logic [RW-2:0]    half;
    comp = '0;
    half = dv_q[DW].root[RW-1:1];
    for (int l = 0; l < 4; l++) begin
      if (dv_q[DW].neg[l]) begin
        comp[l] = (dv_q[DW].dq[l] > DW'(32768)) ? 16'h8000 : 16'(-dv_q[DW].dq[l]);
      end else begin
        comp[l] = (dv_q[DW].dq[l] > DW'(32767)) ? 16'h7fff : dv_q[DW].dq[l][15:0];
      end
    end
    if (dv_q[DW].root == '0) begin
      comp = '0;
    end else begin
      comp[dv_q[DW].half_slot] = (half > (RW-1)'(32767)) ? 16'h7fff : 16'(half);
    end
    out_d.vec_x       = comp[0];
    out_d.vec_y       = comp[1];
    out_d.vec_z       = comp[2];
    out_d.scalar_part = comp[3];
    out_d.clamped     = dv_q[DW].clamp;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
